FILE: rtl/axq_pkg.sv
// ----------------------------------------------------------------------------
// axq_pkg
// Shared constants, branch codes, width and latency helpers for the axes to
// quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package axq_pkg;

   localparam int VALUE_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 14;

   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_RX    = 2'd1;
   localparam logic [1:0] BR_UY    = 2'd2;
   localparam logic [1:0] BR_FZ    = 2'd3;

   // right vector component width
   function automatic int rw_f(input int w, input int f);
      return 2 * w - f + 2;
   endfunction

   // radicand width (signed)
   function automatic int tw_f(input int w, input int f);
      return rw_f(w, f) + 3;
   endfunction

   // numerator width (signed)
   function automatic int dw_f(input int w, input int f);
      return rw_f(w, f) + 1;
   endfunction

   // even width of radicand shifted by the fraction bits
   function automatic int nw_f(input int w, input int f);
      int n;
      n = tw_f(w, f) + f;
      return n + (n & 1);
   endfunction

   function automatic int sqs_f(input int w, input int f);
      return nw_f(w, f) >> 1;
   endfunction

   function automatic int rtw_f(input int w, input int f);
      return sqs_f(w, f) + 1;
   endfunction

   function automatic int qw_f(input int w);
      return w + 1;
   endfunction

   function automatic int dvw_f(input int w, input int f);
      return dw_f(w, f) + f + qw_f(w) + rtw_f(w, f) + 4;
   endfunction

   function automatic int sql_f(input int w, input int f);
      return sqs_f(w, f) + 2;
   endfunction

   function automatic int dvl_f(input int w);
      return qw_f(w) + 2;
   endfunction

   function automatic int lat_f(input int w, input int f);
      return 3 + sql_f(w, f) + dvl_f(w) + 1;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/axq_cross.sv
// ----------------------------------------------------------------------------
// axq_cross
// Two stage right = cross(forward, up): products, then rounded differences.
// ----------------------------------------------------------------------------
`default_nettype none

module axq_cross #(
   parameter int W = axq_pkg::VALUE_WIDTH_DEF,
   parameter int F = axq_pkg::FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic signed [W-1:0]  fx,
   input  wire logic signed [W-1:0]  fy,
   input  wire logic signed [W-1:0]  fz,
   input  wire logic signed [W-1:0]  ux,
   input  wire logic signed [W-1:0]  uy,
   input  wire logic signed [W-1:0]  uz,
   output logic                      out_valid,
   output logic signed [axq_pkg::rw_f(W, F)-1:0] rx,
   output logic signed [axq_pkg::rw_f(W, F)-1:0] ry,
   output logic signed [axq_pkg::rw_f(W, F)-1:0] rz,
   output logic signed [W-1:0]       fx_o,
   output logic signed [W-1:0]       fy_o,
   output logic signed [W-1:0]       fz_o,
   output logic signed [W-1:0]       ux_o,
   output logic signed [W-1:0]       uy_o,
   output logic signed [W-1:0]       uz_o
);

   localparam int RW = axq_pkg::rw_f(W, F);
   localparam int PW = 2 * W;
   localparam logic signed [PW:0] BIAS = (PW + 1)'(1) << (F - 1);

   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [PW-1:0] p0_in, p1_in, p2_in, p3_in, p4_in, p5_in;
   logic signed [W-1:0]  a_ff [6];
   logic signed [W-1:0]  b_ff [6];
   logic                 v1_ff, v2_ff;
   logic signed [RW-1:0] rx_ff, ry_ff, rz_ff;
   logic signed [RW-1:0] rx_in, ry_in, rz_in;

   function automatic logic signed [RW-1:0] rnd_diff(input logic signed [PW-1:0] a,
                                                     input logic signed [PW-1:0] b);
      logic signed [PW:0] d;
      logic signed [PW:0] s;
      d = (PW + 1)'(a) - (PW + 1)'(b) + BIAS;
      s = d >>> F;
      return RW'(s);
   endfunction

   assign p0_in = PW'(fy) * PW'(uz);
   assign p1_in = PW'(fz) * PW'(uy);
   assign p2_in = PW'(fz) * PW'(ux);
   assign p3_in = PW'(fx) * PW'(uz);
   assign p4_in = PW'(fx) * PW'(uy);
   assign p5_in = PW'(fy) * PW'(ux);

   assign rx_in = rnd_diff(p0_ff, p1_ff);
   assign ry_in = rnd_diff(p2_ff, p3_ff);
   assign rz_in = rnd_diff(p4_ff, p5_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      p3_ff <= p3_in;
      p4_ff <= p4_in;
      p5_ff <= p5_in;
      a_ff[0] <= fx;
      a_ff[1] <= fy;
      a_ff[2] <= fz;
      a_ff[3] <= ux;
      a_ff[4] <= uy;
      a_ff[5] <= uz;
      for (int i = 0; i < 6; i++) begin
         b_ff[i] <= a_ff[i];
      end
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      rz_ff <= rz_in;
   end

   assign out_valid = v2_ff;
   assign rx        = rx_ff;
   assign ry        = ry_ff;
   assign rz        = rz_ff;
   assign fx_o      = b_ff[0];
   assign fy_o      = b_ff[1];
   assign fz_o      = b_ff[2];
   assign ux_o      = b_ff[3];
   assign uy_o      = b_ff[4];
   assign uz_o      = b_ff[5];

endmodule

`default_nettype wire

FILE: rtl/axq_select.sv
// ----------------------------------------------------------------------------
// axq_select
// Branch choice, radicand and the four numerators of the quaternion terms.
// ----------------------------------------------------------------------------
`default_nettype none

module axq_select #(
   parameter int W = axq_pkg::VALUE_WIDTH_DEF,
   parameter int F = axq_pkg::FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic signed [axq_pkg::rw_f(W, F)-1:0] rx,
   input  wire logic signed [axq_pkg::rw_f(W, F)-1:0] ry,
   input  wire logic signed [axq_pkg::rw_f(W, F)-1:0] rz,
   input  wire logic signed [W-1:0]  fx,
   input  wire logic signed [W-1:0]  fy,
   input  wire logic signed [W-1:0]  fz,
   input  wire logic signed [W-1:0]  ux,
   input  wire logic signed [W-1:0]  uy,
   input  wire logic signed [W-1:0]  uz,
   output logic                      out_valid,
   output logic [1:0]                branch,
   output logic [axq_pkg::tw_f(W, F)-1:0] rad,
   output logic signed [axq_pkg::dw_f(W, F)-1:0] d0,
   output logic signed [axq_pkg::dw_f(W, F)-1:0] d1,
   output logic signed [axq_pkg::dw_f(W, F)-1:0] d2,
   output logic signed [axq_pkg::dw_f(W, F)-1:0] d3
);

   localparam int TW = axq_pkg::tw_f(W, F);
   localparam int DW = axq_pkg::dw_f(W, F);
   localparam logic signed [TW-1:0] ONE = TW'(1) << F;

   logic signed [TW-1:0] erx, ery, erz, efx, efy, efz, eux, euy, euz;
   logic signed [TW-1:0] t0, t_sel;
   logic [1:0]           br_in, br_ff;
   logic [TW-1:0]        rad_in, rad_ff;
   logic signed [DW-1:0] d0_in, d1_in, d2_in, d3_in;
   logic signed [DW-1:0] d0_ff, d1_ff, d2_ff, d3_ff;
   logic                 v_ff;

   always_comb begin
      erx = TW'(rx);
      ery = TW'(ry);
      erz = TW'(rz);
      efx = TW'(fx);
      efy = TW'(fy);
      efz = TW'(fz);
      eux = TW'(ux);
      euy = TW'(uy);
      euz = TW'(uz);
      t0  = ONE + erx + euy + efz;
      d0_in = '0;
      d1_in = '0;
      d2_in = '0;
      d3_in = '0;
      priority if (t0 > 0) begin
         br_in = axq_pkg::BR_TRACE;
         t_sel = t0;
         d1_in = DW'(euz - efy);
         d2_in = DW'(efx - erz);
         d3_in = DW'(ery - eux);
      end else if (erx > euy && erx > efz) begin
         br_in = axq_pkg::BR_RX;
         t_sel = ONE + erx - euy - efz;
         d0_in = DW'(euz - efy);
         d2_in = DW'(eux + ery);
         d3_in = DW'(efx + erz);
      end else if (euy > efz) begin
         br_in = axq_pkg::BR_UY;
         t_sel = ONE + euy - erx - efz;
         d0_in = DW'(efx - erz);
         d1_in = DW'(eux + ery);
         d3_in = DW'(efy + euz);
      end else begin
         br_in = axq_pkg::BR_FZ;
         t_sel = ONE + efz - erx - euy;
         d0_in = DW'(ery - eux);
         d1_in = DW'(efx + erz);
         d2_in = DW'(efy + euz);
      end
      rad_in = (t_sel < 0) ? '0 : TW'(t_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      br_ff  <= br_in;
      rad_ff <= rad_in;
      d0_ff  <= d0_in;
      d1_ff  <= d1_in;
      d2_ff  <= d2_in;
      d3_ff  <= d3_in;
   end

   assign out_valid = v_ff;
   assign branch    = br_ff;
   assign rad       = rad_ff;
   assign d0        = d0_ff;
   assign d1        = d1_ff;
   assign d2        = d2_ff;
   assign d3        = d3_ff;

endmodule

`default_nettype wire

FILE: rtl/axq_sqrt.sv
// ----------------------------------------------------------------------------
// axq_sqrt
// Pipelined square root of rad * 2^F, one result bit per stage, rounded
// to nearest in a last stage.
// ----------------------------------------------------------------------------
`default_nettype none

module axq_sqrt #(
   parameter int W = axq_pkg::VALUE_WIDTH_DEF,
   parameter int F = axq_pkg::FRAC_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic [axq_pkg::tw_f(W, F)-1:0] rad,
   output logic                             out_valid,
   output logic [axq_pkg::rtw_f(W, F)-1:0]  root
);

   localparam int TW  = axq_pkg::tw_f(W, F);
   localparam int NW  = axq_pkg::nw_f(W, F);
   localparam int SQS = axq_pkg::sqs_f(W, F);
   localparam int RTW = axq_pkg::rtw_f(W, F);
   localparam int RMW = SQS + 3;

   logic [NW-1:0]  n_ff    [SQS+1];
   logic [RMW-1:0] rem_ff  [SQS+1];
   logic [RTW-1:0] root_ff [SQS+1];
   logic           v_ff    [SQS+1];
   logic [RTW-1:0] out_ff, out_in;
   logic           ov_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      n_ff[0]    <= NW'({rad, {F{1'b0}}});
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
   end

   for (genvar j = 1; j <= SQS; j++) begin : g_step
      logic [RMW-1:0] remx, trial;
      logic           ge;

      always_comb begin
         remx  = {rem_ff[j-1][RMW-3:0], n_ff[j-1][NW-1 -: 2]};
         trial = {root_ff[j-1], 2'b01};
         ge    = remx >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= v_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         n_ff[j]    <= n_ff[j-1] << 2;
         rem_ff[j]  <= ge ? remx - trial : remx;
         root_ff[j] <= {root_ff[j-1][RTW-2:0], ge};
      end
   end

   assign out_in = (rem_ff[SQS] > RMW'(root_ff[SQS])) ? root_ff[SQS] + 1'b1
                                                      : root_ff[SQS];

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= v_ff[SQS];
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign out_valid = ov_ff;
   assign root      = out_ff;

endmodule

`default_nettype wire

FILE: rtl/axq_div.sv
// ----------------------------------------------------------------------------
// axq_div
// Pipelined signed division d * 2^F / (2 * root), one quotient bit per
// stage, rounded half away from zero and saturated to the output range.
// ----------------------------------------------------------------------------
`default_nettype none

module axq_div #(
   parameter int W = axq_pkg::VALUE_WIDTH_DEF,
   parameter int F = axq_pkg::FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   input  wire logic signed [axq_pkg::dw_f(W, F)-1:0] num,
   input  wire logic [axq_pkg::rtw_f(W, F)-1:0]    root,
   output logic                                    out_valid,
   output logic signed [W-1:0]                     quot
);

   localparam int DW  = axq_pkg::dw_f(W, F);
   localparam int RTW = axq_pkg::rtw_f(W, F);
   localparam int QW  = axq_pkg::qw_f(W);
   localparam int XW  = axq_pkg::dvw_f(W, F);
   localparam logic [QW:0]  HALF = (QW + 1)'(1) << (W - 1);
   localparam logic [QW:0]  QMAX = HALF - 1'b1;
   localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

   logic [DW-1:0]  mag;
   logic [XW-1:0]  num_in, den_in;
   logic [XW-1:0]  rem_ff [QW+1];
   logic [QW-1:0]  q_ff   [QW+1];
   logic [RTW:0]   s_ff   [QW+1];
   logic           ovf_ff [QW+1];
   logic           neg_ff [QW+1];
   logic           zr_ff  [QW+1];
   logic           v_ff   [QW+1];
   logic [QW:0]    magq, negq;
   logic           rnd;
   logic [W-1:0]   out_in, out_ff;
   logic           ov_ff;

   always_comb begin
      mag    = num[DW-1] ? DW'(-num) : DW'(num);
      num_in = XW'(mag) << F;
      den_in = XW'({root, 1'b0}) << QW;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= num_in;
      q_ff[0]   <= '0;
      s_ff[0]   <= {root, 1'b0};
      zr_ff[0]  <= num == '0;
      neg_ff[0] <= num[DW-1];
      ovf_ff[0] <= (num != '0) && (num_in >= den_in);
   end

   for (genvar j = 1; j <= QW; j++) begin : g_step
      logic [XW-1:0] sh;
      logic          ge;

      always_comb begin
         sh = XW'(s_ff[j-1]) << (QW - j);
         ge = rem_ff[j-1] >= sh;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= v_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j] <= ge ? rem_ff[j-1] - sh : rem_ff[j-1];
         q_ff[j]   <= {q_ff[j-1][QW-2:0], ge};
         s_ff[j]   <= s_ff[j-1];
         zr_ff[j]  <= zr_ff[j-1];
         neg_ff[j] <= neg_ff[j-1];
         ovf_ff[j] <= ovf_ff[j-1];
      end
   end

   always_comb begin
      rnd  = (rem_ff[QW] << 1) >= XW'(s_ff[QW]);
      magq = {1'b0, q_ff[QW]} + (QW + 1)'(rnd);
      negq = ~magq + 1'b1;
      priority if (zr_ff[QW]) begin
         out_in = '0;
      end else if (ovf_ff[QW]) begin
         out_in = neg_ff[QW] ? SMIN : SMAX;
      end else if (neg_ff[QW]) begin
         out_in = (magq > HALF) ? SMIN : negq[W-1:0];
      end else begin
         out_in = (magq > QMAX) ? SMAX : magq[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= v_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign out_valid = ov_ff;
   assign quot      = out_ff;

endmodule

`default_nettype wire

FILE: rtl/axes_to_quaternion.sv
// ----------------------------------------------------------------------------
// axes_to_quaternion
// Forward/up axis pair to unit quaternion, fully pipelined.
//
// Takes one request per clock; busy is always low. Each result appears on the
// rsp_ ports for one cycle with rsp_strobe high, once its request has passed
// the cross, select, root, divide and output stages. The root takes one stage
// per result bit and each divider one stage per quotient bit; these set the
// latency. The receiver cannot stall the pipeline and must take every strobed
// result.
// ----------------------------------------------------------------------------
`default_nettype none

module axes_to_quaternion #(
   parameter int VALUE_WIDTH = axq_pkg::VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = axq_pkg::FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [VALUE_WIDTH-1:0] req_fwd_x,
   input  wire logic signed [VALUE_WIDTH-1:0] req_fwd_y,
   input  wire logic signed [VALUE_WIDTH-1:0] req_fwd_z,
   input  wire logic signed [VALUE_WIDTH-1:0] req_up_x,
   input  wire logic signed [VALUE_WIDTH-1:0] req_up_y,
   input  wire logic signed [VALUE_WIDTH-1:0] req_up_z,
   output logic                               rsp_strobe,
   output logic signed [VALUE_WIDTH-1:0]      rsp_quat_w,
   output logic signed [VALUE_WIDTH-1:0]      rsp_quat_x,
   output logic signed [VALUE_WIDTH-1:0]      rsp_quat_y,
   output logic signed [VALUE_WIDTH-1:0]      rsp_quat_z,
   output logic [1:0]                         rsp_branch_used
);

   localparam int W   = VALUE_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int RW  = axq_pkg::rw_f(W, F);
   localparam int TW  = axq_pkg::tw_f(W, F);
   localparam int DW  = axq_pkg::dw_f(W, F);
   localparam int RTW = axq_pkg::rtw_f(W, F);
   localparam int SQL = axq_pkg::sql_f(W, F);
   localparam int DVL = axq_pkg::dvl_f(W);
   localparam int PL  = 4 * DW + 2;
   localparam int ML  = RTW + 2;
   localparam logic [RTW+W:0] MMAX = (RTW + W + 1)'({1'b0, {(W-1){1'b1}}});

   logic                 c_valid;
   logic signed [RW-1:0] c_rx, c_ry, c_rz;
   logic signed [W-1:0]  c_fx, c_fy, c_fz, c_ux, c_uy, c_uz;

   logic                 s_valid;
   logic [1:0]           s_branch;
   logic [TW-1:0]        s_rad;
   logic signed [DW-1:0] s_d0, s_d1, s_d2, s_d3;

   logic                 r_valid;
   logic [RTW-1:0]       r_root;

   logic [PL-1:0]        pl_ff [SQL];
   logic [ML-1:0]        ml_ff [DVL];
   logic signed [DW-1:0] a_d0, a_d1, a_d2, a_d3;
   logic [1:0]           a_branch, o_branch;
   logic [RTW-1:0]       o_root;

   logic                 q_valid [4];
   logic signed [W-1:0]  q_val   [4];

   logic [RTW:0]         msum;
   logic [W-1:0]         main;
   logic [W-1:0]         w_in, x_in, y_in, z_in;
   logic [W-1:0]         w_ff, x_ff, y_ff, z_ff;
   logic [1:0]           br_ff;
   logic                 st_ff;

   axq_cross #(.W(W), .F(F)) u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .fx        (req_fwd_x),
      .fy        (req_fwd_y),
      .fz        (req_fwd_z),
      .ux        (req_up_x),
      .uy        (req_up_y),
      .uz        (req_up_z),
      .out_valid (c_valid),
      .rx        (c_rx),
      .ry        (c_ry),
      .rz        (c_rz),
      .fx_o      (c_fx),
      .fy_o      (c_fy),
      .fz_o      (c_fz),
      .ux_o      (c_ux),
      .uy_o      (c_uy),
      .uz_o      (c_uz)
   );

   axq_select #(.W(W), .F(F)) u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid),
      .rx        (c_rx),
      .ry        (c_ry),
      .rz        (c_rz),
      .fx        (c_fx),
      .fy        (c_fy),
      .fz        (c_fz),
      .ux        (c_ux),
      .uy        (c_uy),
      .uz        (c_uz),
      .out_valid (s_valid),
      .branch    (s_branch),
      .rad       (s_rad),
      .d0        (s_d0),
      .d1        (s_d1),
      .d2        (s_d2),
      .d3        (s_d3)
   );

   axq_sqrt #(.W(W), .F(F)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .rad       (s_rad),
      .out_valid (r_valid),
      .root      (r_root)
   );

   // hold numerators and branch alongside the root pipeline
   always_ff @(posedge clock) begin
      pl_ff[0] <= {s_d0, s_d1, s_d2, s_d3, s_branch};
      for (int i = 1; i < SQL; i++) begin
         pl_ff[i] <= pl_ff[i-1];
      end
   end

   assign a_d0     = pl_ff[SQL-1][PL-1 -: DW];
   assign a_d1     = pl_ff[SQL-1][PL-1-DW -: DW];
   assign a_d2     = pl_ff[SQL-1][PL-1-2*DW -: DW];
   assign a_d3     = pl_ff[SQL-1][PL-1-3*DW -: DW];
   assign a_branch = pl_ff[SQL-1][1:0];

   axq_div #(.W(W), .F(F)) u_div0 (
      .clock (clock), .reset (reset), .in_valid (r_valid),
      .num (a_d0), .root (r_root), .out_valid (q_valid[0]), .quot (q_val[0])
   );
   axq_div #(.W(W), .F(F)) u_div1 (
      .clock (clock), .reset (reset), .in_valid (r_valid),
      .num (a_d1), .root (r_root), .out_valid (q_valid[1]), .quot (q_val[1])
   );
   axq_div #(.W(W), .F(F)) u_div2 (
      .clock (clock), .reset (reset), .in_valid (r_valid),
      .num (a_d2), .root (r_root), .out_valid (q_valid[2]), .quot (q_val[2])
   );
   axq_div #(.W(W), .F(F)) u_div3 (
      .clock (clock), .reset (reset), .in_valid (r_valid),
      .num (a_d3), .root (r_root), .out_valid (q_valid[3]), .quot (q_val[3])
   );

   // hold root and branch alongside the dividers
   always_ff @(posedge clock) begin
      ml_ff[0] <= {r_root, a_branch};
      for (int i = 1; i < DVL; i++) begin
         ml_ff[i] <= ml_ff[i-1];
      end
   end

   assign o_root   = ml_ff[DVL-1][ML-1:2];
   assign o_branch = ml_ff[DVL-1][1:0];

   always_comb begin
      msum = {1'b0, o_root} + 1'b1;
      main = ((RTW + W + 1)'(msum >> 1) > MMAX) ? MMAX[W-1:0] : W'(msum >> 1);
      w_in = (o_branch == axq_pkg::BR_TRACE) ? main : q_val[0];
      x_in = (o_branch == axq_pkg::BR_RX)    ? main : q_val[1];
      y_in = (o_branch == axq_pkg::BR_UY)    ? main : q_val[2];
      z_in = (o_branch == axq_pkg::BR_FZ)    ? main : q_val[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= 1'b0;
      end else begin
         st_ff <= q_valid[0] && q_valid[1] && q_valid[2] && q_valid[3];
      end
   end

   always_ff @(posedge clock) begin
      w_ff  <= w_in;
      x_ff  <= x_in;
      y_ff  <= y_in;
      z_ff  <= z_in;
      br_ff <= o_branch;
   end

   assign busy            = 1'b0;
   assign rsp_strobe      = st_ff;
   assign rsp_quat_w      = w_ff;
   assign rsp_quat_x      = x_ff;
   assign rsp_quat_y      = y_ff;
   assign rsp_quat_z      = z_ff;
   assign rsp_branch_used = br_ff;

endmodule

`default_nettype wire

FILE: rtl/axq_checker.sv
// ----------------------------------------------------------------------------
// axq_checker
// Port level checks of the axes to quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module axq_checker #(
   parameter int VALUE_WIDTH = axq_pkg::VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = axq_pkg::FRAC_BITS_DEF
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic signed [VALUE_WIDTH-1:0] req_fwd_x,
   input wire logic signed [VALUE_WIDTH-1:0] req_fwd_y,
   input wire logic signed [VALUE_WIDTH-1:0] req_fwd_z,
   input wire logic signed [VALUE_WIDTH-1:0] req_up_x,
   input wire logic signed [VALUE_WIDTH-1:0] req_up_y,
   input wire logic signed [VALUE_WIDTH-1:0] req_up_z,
   input wire logic                          rsp_strobe,
   input wire logic signed [VALUE_WIDTH-1:0] rsp_quat_w,
   input wire logic signed [VALUE_WIDTH-1:0] rsp_quat_x,
   input wire logic signed [VALUE_WIDTH-1:0] rsp_quat_y,
   input wire logic signed [VALUE_WIDTH-1:0] rsp_quat_z,
   input wire logic [1:0]                    rsp_branch_used
);

   localparam int LAT = axq_pkg::lat_f(VALUE_WIDTH, FRAC_BITS);

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_reset_quiet : assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LAT))
      else $error("result without a request at fixed latency");

   a_main_nonneg : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_branch_used == axq_pkg::BR_TRACE && rsp_quat_w >= 0) ||
                     (rsp_branch_used == axq_pkg::BR_RX && rsp_quat_x >= 0) ||
                     (rsp_branch_used == axq_pkg::BR_UY && rsp_quat_y >= 0) ||
                     (rsp_branch_used == axq_pkg::BR_FZ && rsp_quat_z >= 0))
      else $error("main component of chosen branch negative");

endmodule

bind axes_to_quaternion axq_checker #(
   .VALUE_WIDTH (VALUE_WIDTH),
   .FRAC_BITS   (FRAC_BITS)
) u_axq_checker (.*);

`default_nettype wire

FILE: sim/axes_to_quaternion_tb.sv
// ----------------------------------------------------------------------------
// axes_to_quaternion_tb
// Self-checking bench for the forward/up to quaternion pipeline. Directed
// axis pairs and extremes, then random orientations (signed axis swaps,
// perturbed axis swaps, unit-range and full-range vectors) with and without
// random sender gaps. A scoreboard predicts each quaternion and branch code
// and compares every strobed response in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module axes_to_quaternion_tb;

   localparam int W     = 16;
   localparam int F     = 14;
   localparam int LIMIT = 400000;

   typedef struct {
      logic signed [W-1:0] fx, fy, fz, ux, uy, uz;
   } axes_type;

   typedef struct {
      logic signed [W-1:0] w, x, y, z;
      logic [1:0]          br;
   } quat_type;

   class quat_scoreboard;
      quat_type quat_q[$];
      int    errors;
      int    checked;
      int    br_count[4];

      function automatic void sq_step(input longint unsigned pair,
                                      inout longint unsigned rem,
                                      inout longint unsigned root);
         longint unsigned trial;
         rem   = (rem << 2) | pair;
         trial = (root << 2) | 1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      endfunction

      function automatic longint unsigned root_of(input longint unsigned t);
         longint unsigned u, rem, root;
         int z;
         u = t; rem = 0; root = 0; z = F;
         if (F % 2 == 1) begin
            u = t << 1;
            z = F - 1;
         end
         for (int i = 31; i >= 0; i--) sq_step((u >> (2 * i)) & 3, rem, root);
         for (int i = 0; i < z / 2; i++) sq_step(0, rem, root);
         if (rem > root) root++;
         return root;
      endfunction

      function automatic longint quotient(input longint num, input longint unsigned den);
         longint unsigned mag, rem, q, b;
         bit capped;
         if (den == 0) return num > 0 ? (64'sd1 <<< 62) : (num < 0 ? -(64'sd1 <<< 62) : 0);
         mag = num < 0 ? -num : num;
         rem = 0; q = 0; capped = 0;
         for (int i = 0; i < 64 + F; i++) begin
            b   = i < 64 ? (mag >> (63 - i)) & 1 : 0;
            rem = (rem << 1) | b;
            if (q >= (64'd1 << 61)) capped = 1;
            q = q << 1;
            if (rem >= den) begin
               rem = rem - den;
               q   = q | 1;
            end
            if (capped) q = 64'd1 << 62;
         end
         if (!capped && rem >= den - rem) q++;
         return num < 0 ? -longint'(q) : longint'(q);
      endfunction

      function automatic logic signed [W-1:0] clamp(input longint v);
         longint hi, lo;
         hi = (64'sd1 <<< (W - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) v = hi;
         if (v < lo) v = lo;
         return v[W-1:0];
      endfunction

      function automatic quat_type orient_to_quat(input axes_type a);
         longint fx, fy, fz, ux, uy, uz, rx, ry, rz, t, one;
         longint d[4], q[4];
         longint unsigned root;
         logic [1:0] br;
         quat_type r;
         fx = a.fx; fy = a.fy; fz = a.fz; ux = a.ux; uy = a.uy; uz = a.uz;
         one = 64'sd1 <<< F;
         rx = (fy * uz - fz * uy + (64'sd1 <<< (F - 1))) >>> F;
         ry = (fz * ux - fx * uz + (64'sd1 <<< (F - 1))) >>> F;
         rz = (fx * uy - fy * ux + (64'sd1 <<< (F - 1))) >>> F;
         d = '{0, 0, 0, 0};
         t = one + rx + uy + fz;
         if (t > 0) begin
            br = axq_pkg::BR_TRACE;
            d[1] = uz - fy; d[2] = fx - rz; d[3] = ry - ux;
         end else if (rx > uy && rx > fz) begin
            br = axq_pkg::BR_RX;
            t = one + rx - uy - fz;
            d[0] = uz - fy; d[2] = ux + ry; d[3] = fx + rz;
         end else if (uy > fz) begin
            br = axq_pkg::BR_UY;
            t = one + uy - rx - fz;
            d[0] = fx - rz; d[1] = ux + ry; d[3] = fy + uz;
         end else begin
            br = axq_pkg::BR_FZ;
            t = one + fz - rx - uy;
            d[0] = ry - ux; d[1] = fx + rz; d[2] = fy + uz;
         end
         if (t < 0) t = 0;
         root = root_of(t);
         for (int k = 0; k < 4; k++)
            q[k] = (k == br) ? longint'((root + 1) >> 1) : quotient(d[k], root << 1);
         r.w = clamp(q[0]); r.x = clamp(q[1]); r.y = clamp(q[2]); r.z = clamp(q[3]);
         r.br = br;
         return r;
      endfunction

      function void note_request(input axes_type a);
         quat_q.push_back(orient_to_quat(a));
      endfunction

      function void check_result(input quat_type got);
         quat_type exp_q;
         if (quat_q.size() == 0) begin
            $display("%0t: unexpected response w=%0d x=%0d y=%0d z=%0d branch=%0d",
                     $time, got.w, got.x, got.y, got.z, got.br);
            errors++;
            return;
         end
         exp_q = quat_q.pop_front();
         checked++;
         br_count[got.br]++;
         if (got.w !== exp_q.w) begin
            $display("%0t: quat_w expected %0d actual %0d", $time, exp_q.w, got.w);
            errors++;
         end
         if (got.x !== exp_q.x) begin
            $display("%0t: quat_x expected %0d actual %0d", $time, exp_q.x, got.x);
            errors++;
         end
         if (got.y !== exp_q.y) begin
            $display("%0t: quat_y expected %0d actual %0d", $time, exp_q.y, got.y);
            errors++;
         end
         if (got.z !== exp_q.z) begin
            $display("%0t: quat_z expected %0d actual %0d", $time, exp_q.z, got.z);
            errors++;
         end
         if (got.br !== exp_q.br) begin
            $display("%0t: branch expected %0d actual %0d", $time, exp_q.br, got.br);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [W-1:0] req_fwd_x = 0, req_fwd_y = 0, req_fwd_z = 0;
   logic signed [W-1:0] req_up_x = 0, req_up_y = 0, req_up_z = 0;
   logic rsp_strobe;
   logic signed [W-1:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;
   logic [1:0] rsp_branch_used;

   quat_scoreboard sb = new();
   int cycles = 0;
   int gap_pct = 0;
   int sent = 0;

   axes_to_quaternion #(.VALUE_WIDTH(W), .FRAC_BITS(F)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_fwd_x(req_fwd_x), .req_fwd_y(req_fwd_y), .req_fwd_z(req_fwd_z),
      .req_up_x(req_up_x), .req_up_y(req_up_y), .req_up_z(req_up_z),
      .rsp_strobe(rsp_strobe), .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x),
      .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z),
      .rsp_branch_used(rsp_branch_used)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      axes_type a;
      quat_type r;
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("axes_to_quaternion_tb: FAIL");
         $finish;
      end
      if (!reset) begin
         if (start && !busy) begin
            a = '{req_fwd_x, req_fwd_y, req_fwd_z, req_up_x, req_up_y, req_up_z};
            sb.note_request(a);
         end
         if (rsp_strobe) begin
            r = '{rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_branch_used};
            sb.check_result(r);
         end
      end
   end

   task automatic send_request(input axes_type a);
      while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         @(negedge clock);
         start = 0;
      end
      @(negedge clock);
      start = 1;
      {req_fwd_x, req_fwd_y, req_fwd_z} = {a.fx, a.fy, a.fz};
      {req_up_x, req_up_y, req_up_z}    = {a.ux, a.uy, a.uz};
      do @(posedge clock); while (busy);
      sent++;
   endtask

   task automatic send_axes(input int fa, input int fs, input int ua, input int us);
      logic signed [W-1:0] f[3], u[3];
      f = '{0, 0, 0}; u = '{0, 0, 0};
      f[fa] = fs ? -16384 : 16384;
      u[ua] = us ? -16384 : 16384;
      send_request('{f[0], f[1], f[2], u[0], u[1], u[2]});
   endtask

   task automatic drain();
      @(negedge clock);
      start = 0;
      while (sb.quat_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [W-1:0] jitter(input logic signed [W-1:0] v, input int amt);
      return W'(v + $signed($urandom_range(2 * amt)) - amt);
   endfunction

   task automatic send_random();
      axes_type a;
      int fa, ua, sel;
      logic signed [W-1:0] f[3], u[3];
      sel = $urandom_range(99);
      if (sel < 60) begin
         fa = $urandom_range(2);
         ua = (fa + 1 + $urandom_range(1)) % 3;
         f = '{0, 0, 0}; u = '{0, 0, 0};
         f[fa] = $urandom_range(1) ? -16384 : 16384;
         u[ua] = $urandom_range(1) ? -16384 : 16384;
         if (sel >= 25)
            for (int i = 0; i < 3; i++) begin
               f[i] = jitter(f[i], 3000);
               u[i] = jitter(u[i], 3000);
            end
         a = '{f[0], f[1], f[2], u[0], u[1], u[2]};
      end else if (sel < 80) begin
         a = '{jitter(0, 16384), jitter(0, 16384), jitter(0, 16384),
               jitter(0, 16384), jitter(0, 16384), jitter(0, 16384)};
      end else begin
         a = '{W'($urandom), W'($urandom), W'($urandom),
               W'($urandom), W'($urandom), W'($urandom)};
      end
      send_request(a);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: axis pairs for the trace and forward.z branches, then extremes
      send_axes(2, 0, 1, 0);
      send_axes(2, 1, 1, 0);
      send_axes(2, 1, 1, 1);
      send_axes(2, 0, 1, 1);
      send_axes(0, 0, 1, 0);
      send_axes(1, 1, 0, 0);
      send_axes(0, 1, 2, 0);
      send_axes(1, 0, 2, 1);
      send_request('{0, 0, 0, 0, 0, 0});
      send_request('{-32768, -32768, -32768, -32768, -32768, -32768});
      send_request('{32767, 32767, 32767, 32767, 32767, 32767});
      send_request('{32767, -32768, 32767, -32768, 32767, -32768});
      send_request('{0, 0, -32768, 0, -32768, 0});
      send_request('{0, 0, -16384, 0, -16384, 0});
      send_request('{-32768, 0, 0, 0, 0, -32768});
      send_request('{0, -32768, 0, 32767, 0, 0});
      send_request('{0, 0, 16384, 0, 0, 0});
      send_request('{-1, -1, -1, -1, -1, -1});
      drain();

      gap_pct = 26;
      repeat (280) send_random();
      drain();
      gap_pct = 47;
      repeat (280) send_random();
      gap_pct = 0;
      repeat (290) send_random();
      drain();
      repeat (60) @(posedge clock);

      $display("%0d requests sent, %0d responses checked", sent, sb.checked);
      $display("branches seen: trace %0d, right.x %0d, up.y %0d, forward.z %0d",
               sb.br_count[axq_pkg::BR_TRACE], sb.br_count[axq_pkg::BR_RX],
               sb.br_count[axq_pkg::BR_UY], sb.br_count[axq_pkg::BR_FZ]);
      if (sb.errors == 0 && sb.quat_q.size() == 0)
         $display("axes_to_quaternion_tb: PASS");
      else
         $display("axes_to_quaternion_tb: FAIL");
      $finish;
   end

endmodule
